>>> hw/rtl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

    localparam int WORD_W = 32;
    localparam int TEA_CYCLES = 32;
    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] TEA_DEC_SUM = 32'hc6ef_3720;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] block_word_0;
        logic [WORD_W-1:0] block_word_1;
    } tea_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_word_0;
        logic [WORD_W-1:0] result_word_1;
    } tea_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] key_word_0;
        logic [WORD_W-1:0] key_word_1;
        logic [WORD_W-1:0] key_word_2;
        logic [WORD_W-1:0] key_word_3;
    } tea_key_t;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } tea_data_t;

    typedef struct packed {
        logic      valid;
        tea_data_t data;
    } tea_pipe_t;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
    endfunction

endpackage

>>> hw/rtl/tea_cell.sv
`timescale 1ns / 1ps

// One TEA cycle: two half-rounds, one register stage each.
module tea_cell
    import tea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  tea_key_t  key,
    input  tea_pipe_t pipe_in,
    output tea_pipe_t pipe_out
);

    logic              half_valid_reg;
    tea_data_t         half_reg;
    tea_data_t         half_next;
    logic              full_valid_reg;
    tea_data_t         full_reg;
    tea_data_t         full_next;
    logic [WORD_W-1:0] mix_first;
    logic [WORD_W-1:0] mix_second;

    // Encrypt updates word_a first, decrypt word_b first.
    always_comb
    begin
        mix_first = pipe_in.data.action
            ? tea_mix(pipe_in.data.word_a, pipe_in.data.sum, key.key_word_2, key.key_word_3)
            : tea_mix(pipe_in.data.word_b, pipe_in.data.sum, key.key_word_0, key.key_word_1);
        half_next = pipe_in.data;
        if (pipe_in.data.action)
        begin
            half_next.word_b = pipe_in.data.word_b - mix_first;
        end
        else
        begin
            half_next.word_a = pipe_in.data.word_a + mix_first;
        end
    end

    always_comb
    begin
        mix_second = half_reg.action
            ? tea_mix(half_reg.word_b, half_reg.sum, key.key_word_0, key.key_word_1)
            : tea_mix(half_reg.word_a, half_reg.sum, key.key_word_2, key.key_word_3);
        full_next = half_reg;
        if (half_reg.action)
        begin
            full_next.word_a = half_reg.word_a - mix_second;
            full_next.sum    = half_reg.sum - TEA_DELTA;
        end
        else
        begin
            full_next.word_b = half_reg.word_b + mix_second;
            full_next.sum    = half_reg.sum + TEA_DELTA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_valid_reg <= 1'b0;
            full_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            half_valid_reg <= pipe_in.valid;
            full_valid_reg <= half_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            half_reg <= half_next;
            full_reg <= full_next;
        end
    end

    assign pipe_out.valid = full_valid_reg;
    assign pipe_out.data  = full_reg;

endmodule

>>> hw/rtl/tea_block_cipher_unit.sv
`timescale 1ns / 1ps

// TEA block cipher of 32 cells, one per TEA cycle; one 64-bit block per word on each channel.
// Input channel (in_valid/in_ready/in_data): action selects encrypt (0) or
// decrypt (1); the two block words are byte-reversed before the rounds and
// the result words byte-reversed again after them.
// Output channel (out_valid/out_ready/out_data): one result word per input.
// Key: four 32-bit words written through cfg_we/cfg_index/cfg_data, indexes
// 0 to 3; other indexes are ignored. Write the key only while idle.
// Path: the accepting edge loads the first of 64 cell stages (32 cells, each
// one TEA cycle in two register stages); the last cell stage then loads the
// output register, which drives out_valid.
// Throughput: one block per cycle, sustained while out_ready stays high.
// Stall: a result waiting in the output register holds only once the last
// cell carries a word; until then the row keeps filling and in_ready stays
// high. When the last cell holds a word, out_valid is high and out_ready is low, the whole row holds.
// Reset: clears all valid bits and the key words to zero; the block is
// ready as soon as reset is released.
module tea_block_cipher_unit
    import tea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tea_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tea_out_t          out_data,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    localparam logic [7:0] CFG_KEY_0 = 8'd0;
    localparam logic [7:0] CFG_KEY_1 = 8'd1;
    localparam logic [7:0] CFG_KEY_2 = 8'd2;
    localparam logic [7:0] CFG_KEY_3 = 8'd3;

    tea_key_t  key_reg;
    tea_key_t  key_next;
    tea_pipe_t link [0:TEA_CYCLES];
    logic      advance;
    logic      out_valid_reg;
    logic      out_valid_next;
    tea_out_t  out_data_reg;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_0: key_next.key_word_0 = cfg_data;
                CFG_KEY_1: key_next.key_word_1 = cfg_data;
                CFG_KEY_2: key_next.key_word_2 = cfg_data;
                CFG_KEY_3: key_next.key_word_3 = cfg_data;
                default:   key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // Hold the row only when the last cell has a word with nowhere to go.
    assign advance  = !out_valid_reg || out_ready || !link[TEA_CYCLES].valid;
    assign in_ready = advance;

    always_comb
    begin
        link[0].valid       = in_valid;
        link[0].data.action = in_data.action;
        link[0].data.sum    = in_data.action ? TEA_DEC_SUM : TEA_DELTA;
        link[0].data.word_a = swap_bytes(in_data.block_word_0);
        link[0].data.word_b = swap_bytes(in_data.block_word_1);
    end

    for (genvar i = 0; i < TEA_CYCLES; i++)
    begin : g_cell
        tea_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .key      (key_reg),
            .pipe_in  (link[i]),
            .pipe_out (link[i+1])
        );
    end

    always_comb
    begin
        priority if (advance && link[TEA_CYCLES].valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && link[TEA_CYCLES].valid)
        begin
            out_data_reg.result_word_0 <= swap_bytes(link[TEA_CYCLES].data.word_a);
            out_data_reg.result_word_1 <= swap_bytes(link[TEA_CYCLES].data.word_b);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/tea_checker.sv
`timescale 1ns / 1ps

module tea_checker
    import tea_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input tea_out_t out_data
);

    // A result word that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed or dropped while stalled");

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

    // A taking receiver never holds up the input side.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while receiver is ready");

    // An empty output register never holds up the input side.
    a_empty_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

bind tea_block_cipher_unit tea_checker u_tea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> bench/tea_tb_pkg.sv
`timescale 1ns / 1ps

package tea_tb_pkg;

    typedef enum logic [7:0] {
        KEY_WORD_0 = 8'd0,
        KEY_WORD_1 = 8'd1,
        KEY_WORD_2 = 8'd2,
        KEY_WORD_3 = 8'd3
    } key_index_e;

    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } action_e;

endpackage

>>> bench/tea_checker.sv
`timescale 1ns / 1ps

module tea_tb_checker
    import tea_pkg::*;
    import tea_tb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  tea_in_t           in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  tea_out_t          out_data,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    output int                mismatches,
    output int                pending,
    output int                encrypt_count,
    output int                decrypt_count
);

    tea_key_t key_now;
    tea_out_t cipher_fifo[$];

    function automatic logic [WORD_W-1:0] reverse_bytes(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        int i;
        for (i = 0; i < WORD_W / 8; i++)
        begin
            r[8*i +: 8] = w[WORD_W-8-8*i +: 8];
        end
        return r;
    endfunction

    function automatic tea_out_t cipher_block(input tea_in_t blk, input tea_key_t k);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] sum;
        tea_out_t res;
        int n;
        y = reverse_bytes(blk.block_word_0);
        z = reverse_bytes(blk.block_word_1);
        if (blk.action == ACT_ENCRYPT)
        begin
            sum = '0;
            for (n = 0; n < TEA_CYCLES; n++)
            begin
                sum = sum + TEA_DELTA;
                y = y + (((z << 4) + k.key_word_0) ^ (z + sum) ^ ((z >> 5) + k.key_word_1));
                z = z + (((y << 4) + k.key_word_2) ^ (y + sum) ^ ((y >> 5) + k.key_word_3));
            end
        end
        else
        begin
            sum = TEA_DEC_SUM;
            for (n = 0; n < TEA_CYCLES; n++)
            begin
                z = z - (((y << 4) + k.key_word_2) ^ (y + sum) ^ ((y >> 5) + k.key_word_3));
                y = y - (((z << 4) + k.key_word_0) ^ (z + sum) ^ ((z >> 5) + k.key_word_1));
                sum = sum - TEA_DELTA;
            end
        end
        res.result_word_0 = reverse_bytes(y);
        res.result_word_1 = reverse_bytes(z);
        return res;
    endfunction

    task automatic report_mismatch(
        input string             what,
        input logic [WORD_W-1:0] got,
        input logic [WORD_W-1:0] want
    );
        // cap the log, keep counting
        if (mismatches < 20)
        begin
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tea_out_t want;
        if (!rst_n)
        begin
            key_now = '0;
            cipher_fifo.delete();
            mismatches = 0;
            pending <= 0;
            encrypt_count <= 0;
            decrypt_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    KEY_WORD_0: key_now.key_word_0 = cfg_data;
                    KEY_WORD_1: key_now.key_word_1 = cfg_data;
                    KEY_WORD_2: key_now.key_word_2 = cfg_data;
                    KEY_WORD_3: key_now.key_word_3 = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                cipher_fifo.push_back(cipher_block(in_data, key_now));
                if (in_data.action == ACT_ENCRYPT)
                begin
                    encrypt_count <= encrypt_count + 1;
                end
                else
                begin
                    decrypt_count <= decrypt_count + 1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (cipher_fifo.size() == 0)
                begin
                    report_mismatch("unexpected result word, word 0", out_data.result_word_0, '0);
                end
                else
                begin
                    want = cipher_fifo.pop_front();
                    if (out_data.result_word_0 !== want.result_word_0)
                    begin
                        report_mismatch("result_word_0", out_data.result_word_0,
                                        want.result_word_0);
                    end
                    if (out_data.result_word_1 !== want.result_word_1)
                    begin
                        report_mismatch("result_word_1", out_data.result_word_1,
                                        want.result_word_1);
                    end
                end
            end
            pending <= cipher_fifo.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tea_pkg::*;
    import tea_tb_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    tea_in_t           in_data;
    logic              out_valid;
    logic              out_ready;
    tea_out_t          out_data;
    logic              cfg_we;
    logic [7:0]        cfg_index;
    logic [WORD_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int encrypt_count;
    int decrypt_count;
    int key_settings = 0;
    int holds_done = 0;
    bit hold_req = 1'b0;
    bit steady = 1'b0;

    tea_block_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tea_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .encrypt_count (encrypt_count),
        .decrypt_count (decrypt_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("run timed out with %0d blocks outstanding", pending);
        $display("status: fail");
        $finish;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_block(
        input logic              act,
        input logic [WORD_W-1:0] w0,
        input logic [WORD_W-1:0] w1
    );
        tea_in_t word;
        word.action = act;
        word.block_word_0 = w0;
        word.block_word_1 = w1;
        if (!steady)
        begin
            while ($urandom_range(99) < 22)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= word;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [WORD_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_key(
        input logic [WORD_W-1:0] k0,
        input logic [WORD_W-1:0] k1,
        input logic [WORD_W-1:0] k2,
        input logic [WORD_W-1:0] k3
    );
        write_reg(KEY_WORD_0, k0);
        write_reg(KEY_WORD_1, k1);
        write_reg(KEY_WORD_2, k2);
        write_reg(KEY_WORD_3, k3);
        // unmapped indexes must leave the key alone
        write_reg(8'($urandom_range(4, 255)), $urandom);
        write_reg(8'($urandom_range(4, 255)), $urandom);
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_blocks(input int count, input bit with_hold);
        int i;
        for (i = 0; i < count; i++)
        begin
            steady = (i >= count / 3) && (i < count / 3 + 80);
            if (with_hold && i == 20)
            begin
                hold_req = 1'b1;
            end
            send_block(1'($urandom_range(1)), pick_word(), pick_word());
        end
        steady = 1'b0;
    endtask

    // receiver: random stalls, steady windows, and one long hold-off
    initial
    begin
        int held;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                hold_req = 1'b0;
                holds_done++;
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key straight out of reset
        send_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(ACT_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_block(ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_block(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        send_block(ACT_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
        send_block(ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(ACT_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
        send_block(ACT_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
        send_block(ACT_ENCRYPT, 32'h0000_00ff, 32'hff00_0000);
        drain();

        load_key('1, '1, '1, '1);
        send_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(ACT_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_block(ACT_ENCRYPT, 32'hff00_ff00, 32'h00ff_00ff);
        send_block(ACT_DECRYPT, 32'h1234_5678, 32'h9abc_def0);
        random_blocks(150, 1'b0);
        drain();

        load_key(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        random_blocks(200, 1'b0);
        drain();

        load_key($urandom, $urandom, $urandom, $urandom);
        random_blocks(250, 1'b1);
        drain();

        load_key($urandom, $urandom, $urandom, $urandom);
        random_blocks(280, 1'b0);
        drain();

        // latch any stray result past the pipeline depth
        repeat (80) @(posedge clk);

        $display("covered %0d encrypted and %0d decrypted blocks across %0d key loads",
                 encrypt_count, decrypt_count, key_settings + 1);
        $display("output held off %0d time(s) for %0d cycles, %0d mismatches",
                 holds_done, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tea_pkg.sv
hw/rtl/tea_cell.sv
hw/rtl/tea_block_cipher_unit.sv
hw/rtl/tea_checker.sv
bench/tea_tb_pkg.sv
bench/tea_checker.sv
bench/tb.sv
